FILE: hdl/pdm_pkg.sv
// pdm_pkg: shared sizes, codes and controller/datapath interface types
// for the pairwise distance matrix unit
// no dependencies
package pdm_pkg;

  // store geometry
  localparam int MAX_FRAMES  = 1024;
  localparam int MAX_BANDS   = 32;
  localparam int VALUE_WIDTH = 16;

  localparam int FRAME_W  = $clog2(MAX_FRAMES);
  localparam int BAND_W   = $clog2(MAX_BANDS);
  localparam int BCNT_W   = $clog2(MAX_BANDS + 1);
  localparam int ADDR_W   = FRAME_W + BAND_W;
  localparam int DEPTH    = MAX_FRAMES * MAX_BANDS;

  // arithmetic widths
  localparam int SQ_W       = 2 * VALUE_WIDTH;
  localparam int SUM_W      = SQ_W + BAND_W;
  localparam int ROOT_STEPS = (SUM_W + 1) / 2;
  localparam int SUM_PAD_W  = 2 * ROOT_STEPS;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_STEPS + 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int DIST_W     = 19;

  // configuration port
  localparam int CFG_W       = 6;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BANDS = '0;
  localparam logic [CFG_W-1:0] BANDS_RESET   = CFG_W'(24);

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic              load_wr;
    logic              query_take;
    logic              issue;
    logic [BAND_W-1:0] band;
    logic              root_load;
    logic              root_step;
    logic              emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
  } status_t;

endpackage

FILE: hdl/pdm_ram.sv
// pdm_ram: generic memory, one write port and two registered read ports
// no dependencies
module pdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hdl/pdm_ctrl.sv
// pdm_ctrl: sequencer for loads and distance queries
// depends on pdm_pkg
module pdm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        req_type,
  input  logic [pdm_pkg::CFG_W-1:0]   bands,
  input  pdm_pkg::status_t            status,
  output pdm_pkg::cmd_t               cmd,
  output logic                        busy
);
  import pdm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state, state_next;
  logic [BCNT_W-1:0] band_cnt, band_cnt_next;
  logic [STEP_W-1:0] step, step_next;
  logic [BCNT_W-1:0] n_eff;

  // band count clamped to the store width
  always_comb begin
    if (BCNT_W'(bands) > BCNT_W'(MAX_BANDS)) begin
      n_eff = BCNT_W'(MAX_BANDS);
    end else begin
      n_eff = BCNT_W'(bands);
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    band_cnt_next = band_cnt;
    step_next     = step;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.query_take = 1'b1;
            band_cnt_next  = '0;
            state_next     = (n_eff == '0) ? S_DRAIN : S_READ;
          end
        end
      end
      S_READ: begin
        cmd.issue     = 1'b1;
        cmd.band      = band_cnt[BAND_W-1:0];
        band_cnt_next = band_cnt + BCNT_W'(1);
        if (band_cnt == n_eff - BCNT_W'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.root_load = 1'b1;
          step_next     = '0;
          state_next    = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        step_next     = step + STEP_W'(1);
        if (step == STEP_W'(ROOT_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      band_cnt <= '0;
      step     <= '0;
    end else begin
      state    <= state_next;
      band_cnt <= band_cnt_next;
      step     <= step_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: hdl/pdm_datapath.sv
// pdm_datapath: frame store, squared difference pipeline, accumulator
// and bit-by-bit square root; depends on pdm_pkg and pdm_ram
module pdm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  pdm_pkg::cmd_t                     cmd,
  output pdm_pkg::status_t                  status,
  input  logic [pdm_pkg::FRAME_W-1:0]       frame_index,
  input  logic [pdm_pkg::BAND_W-1:0]        band_index,
  input  logic [pdm_pkg::VALUE_WIDTH-1:0]   band_value,
  input  logic [pdm_pkg::FRAME_W-1:0]       other_frame_index,
  output logic                              done,
  output logic [pdm_pkg::FRAME_W-1:0]       row_frame,
  output logic [pdm_pkg::FRAME_W-1:0]       column_frame,
  output logic [pdm_pkg::DIST_W-1:0]        distance
);
  import pdm_pkg::*;

  logic [FRAME_W-1:0]     row, col;
  logic [VALUE_WIDTH-1:0] rdata_a, rdata_b;
  logic [VALUE_WIDTH-1:0] diff;
  logic [SQ_W-1:0]        sq;
  logic                   v1, v2;
  logic [SUM_W-1:0]       acc;
  logic [SUM_PAD_W-1:0]   val;
  logic [REM_W-1:0]       rem, rem_shift, trial;
  logic [ROOT_W-1:0]      root;

  // query frames held for the whole query
  always_ff @(posedge clk) begin
    if (cmd.query_take) begin
      row <= frame_index;
      col <= other_frame_index;
    end
  end

  // frame store
  pdm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (cmd.load_wr),
    .waddr   ({frame_index, band_index}),
    .wdata   (band_value),
    .raddr_a ({row, cmd.band}),
    .raddr_b ({col, cmd.band}),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  assign status.pipe_busy = v1 | v2;

  // absolute difference and square
  assign diff = (rdata_a >= rdata_b) ? rdata_a - rdata_b : rdata_b - rdata_a;

  always_ff @(posedge clk) begin
    if (v1) begin
      sq <= SQ_W'(diff) * SQ_W'(diff);
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (cmd.query_take) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + SUM_W'(sq);
    end
  end

  // square root, two radicand bits a step
  assign rem_shift = {rem[REM_W-3:0], val[SUM_PAD_W-1 -: 2]};
  assign trial     = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      val  <= SUM_PAD_W'(acc);
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      val <= {val[SUM_PAD_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem  <= rem_shift - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_frame    <= row;
      column_frame <= col;
      distance     <= DIST_W'(root);
    end
  end

endmodule

FILE: hdl/pairwise_distance_matrix_unit.sv
// pairwise_distance_matrix_unit: top level, configuration register file,
// controller and datapath; depends on pdm_pkg, pdm_ctrl, pdm_datapath
//
//  channel   signals                                   transaction
//  request   start/busy, req_type, frame_index, ...    start & !busy
//  result    done, row_frame, column_frame, distance   done (one cycle)
//  config    psel/penable/pwrite/paddr/pwdata/prdata   psel & penable & pready
//
// a load writes the store and busy stays low, so loads may follow every cycle
// a query holds busy while it issues one store read per band pair, drains the
// squaring and accumulating pipeline, does one root load and one square root
// step per result bit; done rises in the cycle busy falls
// rst is synchronous; the frame store is not cleared and holds junk until written
// the receiver cannot stall: each result is shown for exactly one cycle
module pairwise_distance_matrix_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic [pdm_pkg::FRAME_W-1:0]         frame_index,
  input  logic [pdm_pkg::BAND_W-1:0]          band_index,
  input  logic [pdm_pkg::VALUE_WIDTH-1:0]     band_value,
  input  logic [pdm_pkg::FRAME_W-1:0]         other_frame_index,
  output logic                                done,
  output logic [pdm_pkg::FRAME_W-1:0]         row_frame,
  output logic [pdm_pkg::FRAME_W-1:0]         column_frame,
  output logic [pdm_pkg::DIST_W-1:0]          distance,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pdm_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [pdm_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [pdm_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import pdm_pkg::*;

  logic [CFG_W-1:0]     bands;
  logic [REG_IDX_W-1:0] reg_idx;
  cmd_t                 cmd;
  status_t              status;

  // configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      bands <= BANDS_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_BANDS) begin
      bands <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx == REG_BANDS) begin
      prdata = APB_DATA_W'(bands);
    end else begin
      prdata = '0;
    end
  end

  // sequencer
  pdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .bands    (bands),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  // store and arithmetic
  pdm_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .frame_index       (frame_index),
    .band_index        (band_index),
    .band_value        (band_value),
    .other_frame_index (other_frame_index),
    .done              (done),
    .row_frame         (row_frame),
    .column_frame      (column_frame),
    .distance          (distance)
  );

  // a result only ends a query
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a query in progress");

  // an accepted query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  // a load neither occupies the block nor gives a result
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_LOAD) |=> (!busy && !done))
    else $error("load disturbed the block");

  // no store read is issued while idle
  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> busy)
    else $error("store read outside a query");

endmodule
